### rtl/address_range_sample_profiler_defines.svh
// Assertion helpers for the sample profiler.
`ifndef ADDRESS_RANGE_SAMPLE_PROFILER_DEFINES_SVH
`define ADDRESS_RANGE_SAMPLE_PROFILER_DEFINES_SVH
`ifndef SYNTHESIS
`define APR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("profiler assertion failed");
`define APR_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("profiler forbidden condition");
`else
`define APR_ASSERT(lbl, prop)
`define APR_NEVER(lbl, expr)
`endif
`endif

### rtl/apr_pkg.sv
package apr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;

  typedef enum logic [2:0] {
    REQ_ENTER  = 3'd0,
    REQ_TICK   = 3'd1,
    REQ_FENTER = 3'd2,
    REQ_FEXIT  = 3'd3,
    REQ_GC     = 3'd4,
    REQ_UNDO   = 3'd5,
    REQ_READ   = 3'd6,
    REQ_NONE   = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOENTRY = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_DISCARD = 2'd0,
    MODE_CREDIT  = 2'd1,
    MODE_OWN     = 2'd2,
    MODE_ALT     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    FLD_ENT  = 3'd0,
    FLD_TICK = 3'd1,
    FLD_FENT = 3'd2,
    FLD_FTCK = 3'd3,
    FLD_GCS  = 3'd4,
    FLD_GCT  = 3'd5
  } fld_e;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] ent;
    logic [31:0] tick;
    logic [31:0] fent;
    logic [31:0] ftick;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

endpackage

### rtl/apr_ram.sv
module apr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/apr_sat.sv
module apr_sat (
  input  logic [31:0] val_i,
  input  logic        dec_i,
  output logic [31:0] res_o
);

  always_comb begin
    if (dec_i) begin
      res_o = (val_i == 32'd0) ? val_i : val_i - 32'd1;
    end else begin
      res_o = (val_i == 32'hFFFF_FFFF) ? val_i : val_i + 32'd1;
    end
  end

endmodule

### rtl/address_range_sample_profiler.sv
// Address-range sample profiler.
// Items: pulse start with req_type_i and its operands while busy is low; the
// item is taken at that edge. One result per item appears on the result ports
// for exactly one cycle, marked by done_o; the receiver cannot stall it.
// Control items (foreign exit, gc toggle that ends collection, discarded
// enter, empty undo) finish straight from idle. Reads pass through S_RD_OUT,
// gc start and gc tick counting through S_GC, and undo through S_UPD_RD and
// S_UPD_WR. Other enters, foreign enter and ticks outside foreign code and
// gc collection run a binary search over the sorted table: each probe reads
// in S_MID and compares in S_CMP through the registered memory read port,
// and the counter update passes through S_UPD_RD and S_UPD_WR.
// Inserting a new address shifts the entries above it up one by one, each
// through S_SH_RD and S_SH_WR, then writes the new row in S_INS.
// A single saturating inc/dec unit serves all counters.
// subfn_mode is to be written over the APB port only while the block is idle; the block itself does not enforce this.
// Reset empties the table (entry count zero) and clears all counters and
// mode bits; no memory clearing pass is needed, rows are written before use.
// The next item may be started in the cycle done_o is high.
module address_range_sample_profiler
  import apr_pkg::*;
#(
  parameter int unsigned TableDepth = apr_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] address_i,
  input  logic        is_subfunction_i,
  input  logic [7:0]  read_index_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] entry_start_o,
  output logic [31:0] enter_total_o,
  output logic [31:0] tick_total_o,
  output logic [31:0] foreign_enter_total_o,
  output logic [31:0] foreign_tick_total_o,
  output logic [8:0]  entries_used_o,
  output logic [31:0] gc_start_total_o,
  output logic [31:0] gc_tick_total_o
);

  `include "address_range_sample_profiler_defines.svh"

  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned IW = $clog2(TableDepth);
  localparam logic [CW-1:0] NoSlot = CW'(TableDepth);
  localparam logic [CW-1:0] TopSlot = CW'(TableDepth - 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MID    = 10'b0000000010,
    S_CMP    = 10'b0000000100,
    S_UPD_RD = 10'b0000001000,
    S_UPD_WR = 10'b0000010000,
    S_SH_RD  = 10'b0000100000,
    S_SH_WR  = 10'b0001000000,
    S_INS    = 10'b0010000000,
    S_RD_OUT = 10'b0100000000,
    S_GC     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  req_e   req_q, req_d;
  mode_e  mode_q, mode_d;
  fld_e   fld_q, fld_d;
  logic          dec_q, dec_d;
  logic          credit_q, credit_d;
  logic [31:0]   addr_q, addr_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          found_q, found_d;
  logic [CW-1:0] tgt_q, tgt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] used_q, used_d;
  logic          in_foreign_q, in_foreign_d;
  logic          collecting_q, collecting_d;
  logic [CW-1:0] fslot_q, fslot_d, last_q, last_d, prior_q, prior_d;
  logic [31:0]   gcs_q, gcs_d, gct_q, gct_d;
  logic          done_q, done_d;
  status_e       status_q, status_d;
  row_t          erow_q, erow_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  row_t          ram_wdata, ram_rdata;
  logic [31:0]   unit_val, unit_res;
  logic [CW:0]   mid_sum;
  logic [IW-1:0] mid;
  logic          cfg_we;

  apr_ram #(.Width(ROW_W), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  apr_sat u_sat (
    .val_i(unit_val),
    .dec_i(dec_q),
    .res_o(unit_res)
  );

  assign cfg_we = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, mode_q} : 32'd0;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = IW'(mid_sum >> 1);

  always_comb begin
    unique case (fld_q)
      FLD_ENT:  unit_val = ram_rdata.ent;
      FLD_TICK: unit_val = ram_rdata.tick;
      FLD_FENT: unit_val = ram_rdata.fent;
      FLD_FTCK: unit_val = ram_rdata.ftick;
      FLD_GCS:  unit_val = gcs_q;
      FLD_GCT:  unit_val = gct_q;
      default:  unit_val = 32'd0;
    endcase
  end

  function automatic logic [CW-1:0] shift_slot(logic [CW-1:0] s, logic [CW-1:0] pos);
    return (s != NoSlot && s >= pos && s < TopSlot) ? s + CW'(1) : s;
  endfunction

  always_comb begin
    logic [1:0]    eff_mode;
    logic [CW-1:0] nm1;
    logic          fin;
    status_e       fin_st;
    row_t          wrow;

    state_d = state_q;    req_d = req_q;     mode_d = mode_q;
    fld_d = fld_q;        dec_d = dec_q;     credit_d = credit_q;
    addr_d = addr_q;      lo_d = lo_q;       hi_d = hi_q;
    found_d = found_q;    tgt_d = tgt_q;     idx_d = idx_q;
    used_d = used_q;      in_foreign_d = in_foreign_q;
    collecting_d = collecting_q;
    fslot_d = fslot_q;    last_d = last_q;   prior_d = prior_q;
    gcs_d = gcs_q;        gct_d = gct_q;
    done_d = 1'b0;        status_d = status_q; erow_d = erow_q;
    ram_we = 1'b0;        ram_waddr = '0;    ram_raddr = '0;
    ram_wdata = ram_rdata;
    fin = 1'b0;           fin_st = ST_OK;
    eff_mode = is_subfunction_i ? mode_q : MODE_OWN;
    nm1 = lo_q - CW'(1);
    wrow = ram_rdata;

    if (cfg_we && paddr[2] == 1'b0) begin
      mode_d = mode_e'(pwdata[1:0]);
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_e'(req_type_i);
          addr_d = address_i;
          lo_d = '0;
          hi_d = used_q;
          found_d = 1'b0;
          dec_d = 1'b0;
          unique case (req_e'(req_type_i))
            REQ_ENTER: begin
              if (eff_mode == MODE_DISCARD || eff_mode == MODE_ALT) begin
                prior_d = last_q;
                last_d = NoSlot;
                fin = 1'b1;
              end else begin
                credit_d = (eff_mode == MODE_CREDIT);
                state_d = S_MID;
              end
            end
            REQ_TICK: begin
              if (in_foreign_q) begin
                if (fslot_q < used_q) begin
                  tgt_d = fslot_q;
                  fld_d = FLD_FTCK;
                  state_d = S_UPD_RD;
                end else begin
                  fin = 1'b1;
                  fin_st = ST_NOENTRY;
                end
              end else if (collecting_q) begin
                fld_d = FLD_GCT;
                state_d = S_GC;
              end else begin
                state_d = S_MID;
              end
            end
            REQ_FENTER: begin
              in_foreign_d = 1'b1;
              state_d = S_MID;
            end
            REQ_FEXIT: begin
              in_foreign_d = 1'b0;
              fin = 1'b1;
            end
            REQ_GC: begin
              if (collecting_q) begin
                collecting_d = 1'b0;
                fin = 1'b1;
              end else begin
                collecting_d = 1'b1;
                fld_d = FLD_GCS;
                state_d = S_GC;
              end
            end
            REQ_UNDO: begin
              if (last_q < used_q) begin
                tgt_d = last_q;
                fld_d = FLD_ENT;
                dec_d = 1'b1;
                last_d = prior_q;
                state_d = S_UPD_RD;
              end else begin
                fin = 1'b1;
              end
            end
            REQ_READ: begin
              if (16'(read_index_i) < 16'(used_q)) begin
                ram_raddr = IW'(read_index_i);
                state_d = S_RD_OUT;
              end else begin
                fin = 1'b1;
                fin_st = ST_RANGE;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_MID: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid;
          state_d = S_CMP;
        end else begin
          // search done: lo holds the count of entries at or below the address
          unique case (req_q)
            REQ_ENTER: begin
              if (found_q || (credit_q && lo_q != '0)) begin
                tgt_d = nm1;
                fld_d = FLD_ENT;
                prior_d = last_q;
                last_d = nm1;
                state_d = S_UPD_RD;
              end else if (credit_q) begin
                fin = 1'b1;
                fin_st = ST_NOENTRY;
              end else if (used_q >= NoSlot) begin
                fin = 1'b1;
                fin_st = ST_FULL;
              end else if (used_q > lo_q) begin
                idx_d = used_q;
                state_d = S_SH_RD;
              end else begin
                state_d = S_INS;
              end
            end
            REQ_TICK: begin
              if (lo_q == '0) begin
                fin = 1'b1;
                fin_st = ST_NOENTRY;
              end else begin
                tgt_d = nm1;
                fld_d = FLD_TICK;
                state_d = S_UPD_RD;
              end
            end
            default: begin
              if (lo_q == '0) begin
                fslot_d = NoSlot;
                fin = 1'b1;
                fin_st = ST_NOENTRY;
              end else begin
                fslot_d = nm1;
                tgt_d = nm1;
                fld_d = FLD_FENT;
                state_d = S_UPD_RD;
              end
            end
          endcase
        end
      end
      S_CMP: begin
        if (ram_rdata.start <= addr_q) begin
          lo_d = CW'(mid) + CW'(1);
        end else begin
          hi_d = CW'(mid);
        end
        if (ram_rdata.start == addr_q) begin
          found_d = 1'b1;
        end
        state_d = S_MID;
      end
      S_UPD_RD: begin
        ram_raddr = IW'(tgt_q);
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        unique case (fld_q)
          FLD_ENT:  wrow.ent = unit_res;
          FLD_TICK: wrow.tick = unit_res;
          FLD_FENT: wrow.fent = unit_res;
          default:  wrow.ftick = unit_res;
        endcase
        ram_we = 1'b1;
        ram_waddr = IW'(tgt_q);
        ram_wdata = wrow;
        fin = 1'b1;
      end
      S_SH_RD: begin
        ram_raddr = IW'(idx_q - CW'(1));
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        // move one entry up; stop once the gap sits at the insert position
        ram_we = 1'b1;
        ram_waddr = IW'(idx_q);
        ram_wdata = ram_rdata;
        idx_d = idx_q - CW'(1);
        state_d = (idx_q - CW'(1) == lo_q) ? S_INS : S_SH_RD;
      end
      S_INS: begin
        ram_we = 1'b1;
        ram_waddr = IW'(lo_q);
        ram_wdata = '{start: addr_q, ent: 32'd1, tick: 32'd0, fent: 32'd0,
                      ftick: 32'd0};
        used_d = used_q + CW'(1);
        fslot_d = shift_slot(fslot_q, lo_q);
        prior_d = shift_slot(last_q, lo_q);
        last_d = lo_q;
        fin = 1'b1;
      end
      S_RD_OUT: begin
        fin = 1'b1;
      end
      S_GC: begin
        if (fld_q == FLD_GCS) begin
          gcs_d = unit_res;
        end else begin
          gct_d = unit_res;
        end
        fin = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      state_d = S_IDLE;
      done_d = 1'b1;
      status_d = fin_st;
      erow_d = (state_q == S_RD_OUT) ? ram_rdata : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q <= REQ_NONE;
      mode_q <= MODE_DISCARD;
      fld_q <= FLD_ENT;
      dec_q <= 1'b0;
      credit_q <= 1'b0;
      lo_q <= '0;
      hi_q <= '0;
      found_q <= 1'b0;
      tgt_q <= '0;
      idx_q <= '0;
      used_q <= '0;
      in_foreign_q <= 1'b0;
      collecting_q <= 1'b0;
      fslot_q <= NoSlot;
      last_q <= NoSlot;
      prior_q <= NoSlot;
      gcs_q <= '0;
      gct_q <= '0;
      done_q <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q <= state_d;
      req_q <= req_d;
      mode_q <= mode_d;
      fld_q <= fld_d;
      dec_q <= dec_d;
      credit_q <= credit_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
      found_q <= found_d;
      tgt_q <= tgt_d;
      idx_q <= idx_d;
      used_q <= used_d;
      in_foreign_q <= in_foreign_d;
      collecting_q <= collecting_d;
      fslot_q <= fslot_d;
      last_q <= last_d;
      prior_q <= prior_d;
      gcs_q <= gcs_d;
      gct_q <= gct_d;
      done_q <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    erow_q <= erow_d;
  end

  assign busy                  = (state_q != S_IDLE);
  assign done_o                = done_q;
  assign status_o              = status_q;
  assign entry_start_o         = erow_q.start;
  assign enter_total_o         = erow_q.ent;
  assign tick_total_o          = erow_q.tick;
  assign foreign_enter_total_o = erow_q.fent;
  assign foreign_tick_total_o  = erow_q.ftick;
  assign entries_used_o        = 9'(used_q);
  assign gc_start_total_o      = gcs_q;
  assign gc_tick_total_o       = gct_q;

  `APR_NEVER(a_used_bound, used_q > NoSlot)
  `APR_ASSERT(a_done_idle, done_o |-> (state_q == S_IDLE))
  `APR_ASSERT(a_we_state, ram_we |-> (state_q == S_UPD_WR || state_q == S_SH_WR || state_q == S_INS))
  `APR_ASSERT(a_ins_grow, (state_q == S_INS) |=> (used_q == $past(used_q) + CW'(1)))

endmodule
